### rtl/osm_pkg.sv
`timescale 1ns / 1ps
// Package for the order-statistics multiset: action and status codes,
// the control bundle sent to the cell row, and default sizes. No dependencies.
package osm_pkg;

    localparam int OSM_CAPACITY  = 1024;
    localparam int OSM_KEY_WIDTH = 32;

    typedef enum logic [2:0] {
        ACT_INSERT = 3'd0,
        ACT_DELETE = 3'd1,
        ACT_RANK   = 3'd2,
        ACT_KTH    = 3'd3,
        ACT_PRED   = 3'd4,
        ACT_SUCC   = 3'd5
    } osm_action_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_NONE = 2'd1,
        ST_FULL = 2'd2
    } osm_status_t;

    // Strobes from the sequencer to every cell of the row.
    typedef struct packed {
        logic cmp;   // latch compare flags against the incoming key
        logic ins;   // open a slot and write the insert key
        logic del;   // close the slot of the first equal key
    } osm_ctrl_t;

endpackage

### rtl/osm_cell.sv
`timescale 1ns / 1ps
// One slot of the sorted key row: holds a key, compares it with a broadcast
// key, and shifts to or from its neighbors. Depends on osm_pkg.
module osm_cell
    import osm_pkg::*;
#(
    parameter int KEY_WIDTH = OSM_KEY_WIDTH,
    parameter int IDX_WIDTH = 10,
    parameter int CNT_WIDTH = 11,
    parameter int INDEX     = 0
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  osm_ctrl_t            ctrl,
    input  logic [KEY_WIDTH-1:0] cmp_key,
    input  logic [KEY_WIDTH-1:0] ins_key,
    input  logic [CNT_WIDTH-1:0] key_count,
    input  logic [KEY_WIDTH-1:0] left_key,
    input  logic                 left_le,
    input  logic [KEY_WIDTH-1:0] right_key,
    input  logic [IDX_WIDTH-1:0] sel_idx,
    output logic [KEY_WIDTH-1:0] key_q,
    output logic                 lt,
    output logic                 le,
    output logic [KEY_WIDTH-1:0] sel_key
);

    logic [KEY_WIDTH-1:0] key_reg;
    logic                 lt_reg;
    logic                 le_reg;
    logic                 occ;

    assign occ = CNT_WIDTH'(INDEX) < key_count;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lt_reg <= 1'b0;
            le_reg <= 1'b0;
        end
        else if (ctrl.cmp)
        begin
            lt_reg <= occ && (key_reg < cmp_key);
            le_reg <= occ && (key_reg <= cmp_key);
        end
    end

    // Slots at or past the insert point move one place up; slots at or past
    // the delete point take the key from above.
    always_ff @(posedge clk)
    begin
        if (ctrl.ins && !le_reg)
        begin
            key_reg <= left_le ? ins_key : left_key;
        end
        else if (ctrl.del && !lt_reg)
        begin
            key_reg <= right_key;
        end
    end

    assign key_q   = key_reg;
    assign lt      = lt_reg;
    assign le      = le_reg;
    assign sel_key = (sel_idx == IDX_WIDTH'(INDEX)) ? key_reg : '0;

endmodule

### rtl/order_statistics_multiset.sv
`timescale 1ns / 1ps
// Sorted multiset of signed keys held in a row of compare-and-shift cells.
// The sequencer steps through compare, encode, select and execute for each beat,
// takes no new beat while busy, and pulses done after the execute step.
// Reset clears the key count and control state; stored keys are not cleared.
// The result beat cannot be stalled by the receiver.
module order_statistics_multiset
    import osm_pkg::*;
#(
    parameter int CAPACITY  = OSM_CAPACITY,
    parameter int KEY_WIDTH = OSM_KEY_WIDTH,
    localparam int IDX_W    = $clog2(CAPACITY),
    localparam int CNT_W    = $clog2(CAPACITY + 1),
    localparam int RANK_W   = $clog2(CAPACITY + 2)
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [2:0]                  action,
    input  logic signed [KEY_WIDTH-1:0] key,
    input  logic [CNT_W-1:0]            position,
    output logic                        done,
    output logic signed [KEY_WIDTH-1:0] found_key,
    output logic [RANK_W-1:0]           key_rank,
    output logic [1:0]                  status
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_ENC  = 4'b0010,
        S_SEL  = 4'b0100,
        S_EXEC = 4'b1000
    } state_t;

    localparam logic [KEY_WIDTH-1:0] SIGN_BIT = {1'b1, {(KEY_WIDTH-1){1'b0}}};

    state_t state_reg, state_next;

    logic [2:0]           act_reg;
    logic [KEY_WIDTH-1:0] key_reg;
    logic [CNT_W-1:0]     pos_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     below_reg, below_next;
    logic [CNT_W-1:0]     na_reg, na_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [1:0]           pend_status_reg, pend_status_next;
    logic [RANK_W-1:0]    pend_rank_reg, pend_rank_next;
    logic                 hit_reg, hit_next;
    logic                 ins_go_reg, ins_go_next;
    logic                 del_go_reg, del_go_next;

    logic                 done_reg;
    logic [KEY_WIDTH-1:0] found_reg, found_next;
    logic [RANK_W-1:0]    rank_out_reg;
    logic [1:0]           status_out_reg;

    logic                 accept;
    logic [KEY_WIDTH-1:0] cmp_key;
    osm_ctrl_t            ctrl;

    logic [KEY_WIDTH-1:0] cell_key [CAPACITY];
    logic [KEY_WIDTH-1:0] cell_sel [CAPACITY];
    logic [CAPACITY-1:0]  lt_vec;
    logic [CAPACITY-1:0]  le_vec;
    logic [CAPACITY-1:0]  lt_up;
    logic [CAPACITY-1:0]  le_up;
    logic [KEY_WIDTH-1:0] sel_or;

    assign busy    = (state_reg != S_IDLE);
    assign accept  = start && !busy;
    assign cmp_key = KEY_WIDTH'(key) ^ SIGN_BIT;

    assign ctrl.cmp = accept;
    assign ctrl.ins = (state_reg == S_EXEC) && ins_go_reg;
    assign ctrl.del = (state_reg == S_EXEC) && del_go_reg;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            osm_cell #(
                .KEY_WIDTH (KEY_WIDTH),
                .IDX_WIDTH (IDX_W),
                .CNT_WIDTH (CNT_W),
                .INDEX     (gi)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (ctrl),
                .cmp_key   (cmp_key),
                .ins_key   (key_reg),
                .key_count (count_reg),
                .left_key  ((gi == 0) ? '0 : cell_key[(gi == 0) ? 0 : gi - 1]),
                .left_le   ((gi == 0) ? 1'b1 : le_vec[(gi == 0) ? 0 : gi - 1]),
                .right_key (cell_key[(gi == CAPACITY - 1) ? gi : gi + 1]),
                .sel_idx   (idx_reg),
                .key_q     (cell_key[gi]),
                .lt        (lt_vec[gi]),
                .le        (le_vec[gi]),
                .sel_key   (cell_sel[gi])
            );
        end
    endgenerate

    // The flags form a prefix of ones, so the count is the index just past
    // the last set flag: a one-hot edge encoded by an OR tree.
    assign lt_up = lt_vec >> 1;
    assign le_up = le_vec >> 1;

    always_comb
    begin
        below_next = '0;
        na_next    = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (lt_vec[i] && !lt_up[i])
            begin
                below_next = below_next | CNT_W'(i + 1);
            end
            if (le_vec[i] && !le_up[i])
            begin
                na_next = na_next | CNT_W'(i + 1);
            end
        end
    end

    always_comb
    begin
        sel_or = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            sel_or = sel_or | cell_sel[i];
        end
    end

    always_comb
    begin
        pend_status_next = ST_OK;
        pend_rank_next   = '0;
        idx_next         = '0;
        hit_next         = 1'b0;
        ins_go_next      = 1'b0;
        del_go_next      = 1'b0;
        case (act_reg)
            ACT_INSERT:
            begin
                if (count_reg >= CNT_W'(CAPACITY))
                begin
                    pend_status_next = ST_FULL;
                end
                else
                begin
                    ins_go_next = 1'b1;
                end
            end
            ACT_DELETE:
            begin
                del_go_next = (na_reg != below_reg);
            end
            ACT_RANK:
            begin
                pend_rank_next = RANK_W'(below_reg) + RANK_W'(1);
            end
            ACT_KTH:
            begin
                if (pos_reg == '0 || pos_reg > count_reg)
                begin
                    pend_status_next = ST_NONE;
                end
                else
                begin
                    idx_next = IDX_W'(pos_reg - CNT_W'(1));
                    hit_next = 1'b1;
                end
            end
            ACT_PRED:
            begin
                if (below_reg == '0)
                begin
                    pend_status_next = ST_NONE;
                end
                else
                begin
                    idx_next = IDX_W'(below_reg - CNT_W'(1));
                    hit_next = 1'b1;
                end
            end
            ACT_SUCC:
            begin
                if (na_reg >= count_reg)
                begin
                    pend_status_next = ST_NONE;
                end
                else
                begin
                    idx_next = IDX_W'(na_reg);
                    hit_next = 1'b1;
                end
            end
            default:
            begin
                pend_status_next = ST_NONE;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (accept) state_next = S_ENC;
            S_ENC:   state_next = S_SEL;
            S_SEL:   state_next = S_EXEC;
            S_EXEC:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    assign found_next = hit_reg ? (sel_or ^ SIGN_BIT) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            done_reg   <= 1'b0;
            ins_go_reg <= 1'b0;
            del_go_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == S_EXEC);
            if (state_reg == S_SEL)
            begin
                ins_go_reg <= ins_go_next;
                del_go_reg <= del_go_next;
            end
            if (ctrl.ins)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (ctrl.del)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg <= action;
            key_reg <= cmp_key;
            pos_reg <= position;
        end
        if (state_reg == S_ENC)
        begin
            below_reg <= below_next;
            na_reg    <= na_next;
        end
        if (state_reg == S_SEL)
        begin
            pend_status_reg <= pend_status_next;
            pend_rank_reg   <= pend_rank_next;
            idx_reg         <= idx_next;
            hit_reg         <= hit_next;
        end
        if (state_reg == S_EXEC)
        begin
            found_reg      <= found_next;
            rank_out_reg   <= pend_rank_reg;
            status_out_reg <= pend_status_reg;
        end
    end

    assign done      = done_reg;
    assign found_key = found_reg;
    assign key_rank  = rank_out_reg;
    assign status    = status_out_reg;

endmodule

### rtl/osm_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the order-statistics multiset, bound to the top level.
// Depends on osm_pkg and order_statistics_multiset.
module osm_port_checks
    import osm_pkg::*;
#(
    parameter int KEY_WIDTH = OSM_KEY_WIDTH,
    parameter int RANK_W    = 11
)
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 start,
    input logic                 busy,
    input logic                 done,
    input logic [KEY_WIDTH-1:0] found_key,
    input logic [RANK_W-1:0]    key_rank,
    input logic [1:0]           status
);

    // An accepted beat keeps the block busy until its result is out.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after an accepted beat");

    // Every accepted beat yields its result a fixed time later.
    a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##4 done)
        else $error("result did not follow an accepted beat");

    a_done_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while still busy");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status == ST_OK || status == ST_NONE || status == ST_FULL))
        else $error("undefined status code");

    // A failing status carries a zero key and a zero rank.
    a_no_key_on_failure: assert property (@(posedge clk) disable iff (!rst_n)
        done && status != ST_OK |-> found_key == '0 && key_rank == '0)
        else $error("key reported with a failing status");

endmodule

bind order_statistics_multiset osm_port_checks #(
    .KEY_WIDTH (KEY_WIDTH),
    .RANK_W    (RANK_W)
) u_osm_port_checks (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .done      (done),
    .found_key (found_key),
    .key_rank  (key_rank),
    .status    (status)
);

### bench/osm_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the order-statistics multiset: watches command and result beats,
// keeps its own sorted copy of the store and compares every result field by field.
// Depends on osm_pkg for sizes and for the action and status codes.
module osm_checker
    import osm_pkg::*;
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic                            busy,
    input  logic [2:0]                      action,
    input  logic signed [OSM_KEY_WIDTH-1:0] key,
    input  logic [$clog2(OSM_CAPACITY+1)-1:0] position,
    input  logic                            done,
    input  logic signed [OSM_KEY_WIDTH-1:0] found_key,
    input  logic [$clog2(OSM_CAPACITY+2)-1:0] key_rank,
    input  logic [1:0]                      status,
    output int                              error_count,
    output int                              pending_count
);

    localparam int KW = OSM_KEY_WIDTH;
    localparam int CW = $clog2(OSM_CAPACITY + 1);
    localparam int RW = $clog2(OSM_CAPACITY + 2);

    typedef struct packed {
        logic signed [KW-1:0] found;
        logic [RW-1:0]        rank;
        osm_status_t          st;
    } query_result_t;

    logic signed [KW-1:0] sorted_store [OSM_CAPACITY];
    int                   stored_keys = 0;
    query_result_t        awaited_results [$];

    function automatic int keys_below(logic signed [KW-1:0] k);
        int n;
        n = 0;
        for (int i = 0; i < stored_keys; i++)
            if (sorted_store[i] < k)
                n++;
        return n;
    endfunction

    function automatic int keys_not_above(logic signed [KW-1:0] k);
        int n;
        n = 0;
        for (int i = 0; i < stored_keys; i++)
            if (sorted_store[i] <= k)
                n++;
        return n;
    endfunction

    task automatic report_mismatch(string msg);
        // Keep the log readable when the block is badly broken; every error still counts.
        if (error_count < 100)
            $display("%t osm_checker: %s", $realtime, msg);
        error_count++;
    endtask

    // Updates the store copy for one accepted command beat and queues its result.
    task automatic apply_command(logic [2:0] a, logic signed [KW-1:0] k, logic [CW-1:0] p);
        query_result_t r;
        int            idx;
        r.found = '0;
        r.rank  = '0;
        r.st    = ST_OK;
        case (a)
            ACT_INSERT:
            begin
                if (stored_keys >= OSM_CAPACITY)
                    r.st = ST_FULL;
                else
                begin
                    idx = keys_not_above(k);
                    for (int i = stored_keys; i > idx; i--)
                        sorted_store[i] = sorted_store[i-1];
                    sorted_store[idx] = k;
                    stored_keys++;
                end
            end
            ACT_DELETE:
            begin
                idx = keys_below(k);
                if (idx < stored_keys && sorted_store[idx] == k)
                begin
                    for (int i = idx; i + 1 < stored_keys; i++)
                        sorted_store[i] = sorted_store[i+1];
                    stored_keys--;
                end
            end
            ACT_RANK:
                r.rank = RW'(keys_below(k) + 1);
            ACT_KTH:
            begin
                if (p == 0 || int'(p) > stored_keys)
                    r.st = ST_NONE;
                else
                    r.found = sorted_store[int'(p) - 1];
            end
            ACT_PRED:
            begin
                idx = keys_below(k);
                if (idx == 0)
                    r.st = ST_NONE;
                else
                    r.found = sorted_store[idx-1];
            end
            ACT_SUCC:
            begin
                idx = keys_not_above(k);
                if (idx >= stored_keys)
                    r.st = ST_NONE;
                else
                    r.found = sorted_store[idx];
            end
            default:
                r.st = ST_NONE;
        endcase
        awaited_results.push_back(r);
    endtask

    always @(posedge clk)
    begin : watch
        query_result_t want;
        if (!rst_n)
        begin
            awaited_results.delete();
            stored_keys = 0;
            error_count = 0;
        end
        else
        begin
            if (done)
            begin
                if (awaited_results.size() == 0)
                    report_mismatch("result beat with no command outstanding");
                else
                begin
                    want = awaited_results.pop_front();
                    if (found_key !== want.found)
                        report_mismatch($sformatf("found_key got %0d expected %0d",
                                                  found_key, want.found));
                    if (key_rank !== want.rank)
                        report_mismatch($sformatf("key_rank got %0d expected %0d",
                                                  key_rank, want.rank));
                    if (status !== want.st)
                        report_mismatch($sformatf("status got %0d expected %0d",
                                                  status, want.st));
                end
            end
            if (start && !busy)
                apply_command(action, key, position);
        end
        pending_count = awaited_results.size();
    end

endmodule

### bench/tb_order_statistics_multiset.sv
`timescale 1ns / 1ps
// Top of the order-statistics multiset bench: clock, reset and command stimulus
// with random gaps; results are judged by osm_checker. Depends on osm_pkg and the RTL.
module tb_order_statistics_multiset;
    import osm_pkg::*;

    localparam int KW = OSM_KEY_WIDTH;
    localparam int CW = $clog2(OSM_CAPACITY + 1);
    localparam int RW = $clog2(OSM_CAPACITY + 2);

    // Action codes the block does not define; they must answer with status none.
    localparam logic [2:0] ACT_SPARE_LO = 3'd6;
    localparam logic [2:0] ACT_SPARE_HI = 3'd7;

    localparam logic signed [KW-1:0] KEY_MIN = {1'b1, {(KW-1){1'b0}}};
    localparam logic signed [KW-1:0] KEY_MAX = {1'b0, {(KW-1){1'b1}}};

    localparam int POOL_SIZE = 24;

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 start    = 1'b0;
    logic [2:0]           action   = '0;
    logic signed [KW-1:0] key      = '0;
    logic [CW-1:0]        position = '0;
    logic                 busy;
    logic                 done;
    logic signed [KW-1:0] found_key;
    logic [RW-1:0]        key_rank;
    logic [1:0]           status;
    int                   error_count;
    int                   pending_count;

    logic signed [KW-1:0] key_pool [POOL_SIZE];
    int                   approx_count = 0;
    int                   beats_sent   = 0;
    bit                   burst_mode   = 1'b0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    order_statistics_multiset u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .action    (action),
        .key       (key),
        .position  (position),
        .done      (done),
        .found_key (found_key),
        .key_rank  (key_rank),
        .status    (status)
    );

    osm_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .action        (action),
        .key           (key),
        .position      (position),
        .done          (done),
        .found_key     (found_key),
        .key_rank      (key_rank),
        .status        (status),
        .error_count   (error_count),
        .pending_count (pending_count)
    );

    // Drives one command beat and returns at the edge that accepts it. With no gap,
    // start stays high so back-to-back beats are offered without a dead cycle.
    task automatic send_beat(logic [2:0] a, logic signed [KW-1:0] k, logic [CW-1:0] p);
        int gap;
        if (beats_sent % 25 == 0)
            burst_mode = ($urandom_range(0, 3) == 0);
        gap = burst_mode ? 0 : $urandom_range(0, 16);
        beats_sent++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start    <= 1'b1;
        action   <= a;
        key      <= k;
        position <= p;
        do
            @(posedge clk);
        while (busy);
        if (a == ACT_INSERT && approx_count < OSM_CAPACITY)
            approx_count++;
        else if (a == ACT_DELETE && approx_count > 0)
            approx_count--;
    endtask

    function automatic logic signed [KW-1:0] random_key();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel <= 5)
            return key_pool[$urandom_range(0, POOL_SIZE - 1)];
        else if (sel == 6)
            return KEY_MIN + $urandom_range(0, 2);
        else if (sel == 7)
            return KEY_MAX - $urandom_range(0, 2);
        else
            return $urandom;
    endfunction

    function automatic logic [CW-1:0] random_position();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return '0;
        else if (sel == 1)
            return CW'($urandom);
        else
            return CW'($urandom_range(1, approx_count + 1));
    endfunction

    task automatic send_random_beat();
        int         r;
        logic [2:0] a;
        r = $urandom_range(0, 99);
        if (r < 30)
            a = ACT_INSERT;
        else if (r < 50)
            a = ACT_DELETE;
        else if (r < 62)
            a = ACT_RANK;
        else if (r < 76)
            a = ACT_KTH;
        else if (r < 87)
            a = ACT_PRED;
        else if (r < 98)
            a = ACT_SUCC;
        else
            a = $urandom_range(0, 1) ? ACT_SPARE_HI : ACT_SPARE_LO;
        send_beat(a, random_key(), random_position());
    endtask

    initial
    begin
        #2_000_000;
        $display("tb_order_statistics_multiset: errors");
        $finish;
    end

    initial
    begin
        // A few small keys make duplicates and hits for delete likely.
        for (int i = 0; i < POOL_SIZE; i++)
            key_pool[i] = (i < 8) ? KW'(int'($urandom_range(0, 15)) - 8) : KW'($urandom);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty store: every search misses, rank is one, delete of nothing is fine; then a small store.
        send_beat(ACT_PRED, 0, 1);
        send_beat(ACT_SUCC, 0, 1);
        send_beat(ACT_KTH, 0, 1);
        send_beat(ACT_RANK, KEY_MIN, 1);
        send_beat(ACT_DELETE, 5, 1);
        send_beat(ACT_INSERT, KEY_MIN, 1);
        send_beat(ACT_INSERT, KEY_MAX, 1);
        send_beat(ACT_INSERT, 0, 1);
        send_beat(ACT_INSERT, 0, 1);
        send_beat(ACT_INSERT, -1, 1);
        send_beat(ACT_KTH, 0, 0);
        send_beat(ACT_KTH, 0, 1);
        send_beat(ACT_KTH, 0, 5);
        send_beat(ACT_KTH, 0, 6);
        send_beat(ACT_KTH, 0, {CW{1'b1}});
        send_beat(ACT_RANK, KEY_MAX, 1);
        send_beat(ACT_RANK, 0, 1);
        send_beat(ACT_PRED, KEY_MIN, 1);
        send_beat(ACT_SUCC, KEY_MAX, 1);
        send_beat(ACT_PRED, 0, 1);
        send_beat(ACT_SUCC, 0, 1);
        send_beat(ACT_DELETE, 0, 1);
        send_beat(ACT_RANK, 1, 1);
        send_beat(ACT_SPARE_LO, 3, 2);
        send_beat(ACT_SPARE_HI, KEY_MIN, {CW{1'b1}});
        send_beat(ACT_DELETE, KEY_MIN, 1);

        repeat (170) send_random_beat();

        // Queries at the ends of the key range and of the position range, then a delete and two inserts.
        send_beat(ACT_RANK, KEY_MAX, 1);
        send_beat(ACT_RANK, KEY_MIN, 1);
        send_beat(ACT_KTH, 0, OSM_CAPACITY);
        send_beat(ACT_KTH, 0, OSM_CAPACITY + 1);
        send_beat(ACT_KTH, 0, {CW{1'b1}});
        send_beat(ACT_PRED, KEY_MAX, 1);
        send_beat(ACT_SUCC, KEY_MIN, 1);
        send_beat(ACT_DELETE, key_pool[0], 1);
        send_beat(ACT_INSERT, KEY_MAX, 1);
        send_beat(ACT_INSERT, KEY_MIN, 1);

        // Mostly deletes, with random beats of any action mixed in.
        repeat (130)
        begin
            if ($urandom_range(0, 3) != 0)
                send_beat(ACT_DELETE, random_key(), random_position());
            else
                send_random_beat();
        end

        repeat (60) send_random_beat();

        start <= 1'b0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (8) @(posedge clk);
        @(negedge clk);
        if (error_count == 0)
            $display("tb_order_statistics_multiset: clean");
        else
            $display("tb_order_statistics_multiset: errors");
        $finish;
    end

endmodule

### files.f
rtl/osm_pkg.sv
rtl/osm_cell.sv
rtl/order_statistics_multiset.sv
rtl/osm_checker.sv
bench/osm_checker.sv
bench/tb_order_statistics_multiset.sv
